// ----- design/servo_ramp_pwm_controller_core_assert.svh -----
// ----------------------------------------------------------------------------
// Servo ramp PWM controller assertion macros
// Concurrent assertion wrappers shared by the controller modules.
// ----------------------------------------------------------------------------
`ifndef SERVO_RAMP_PWM_CONTROLLER_CORE_ASSERT_SVH
`define SERVO_RAMP_PWM_CONTROLLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while in reset
`define SRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// next-cycle implication, disabled while in reset
`define SRP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define SRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

// ----- design/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo ramp PWM controller package
// Shared types, command and register codes, and reset constants.
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int C_QUEUE_DEPTH = 2;

    localparam logic [14:0] C_PULSE_MIN_RST = 15'd500;
    localparam logic [14:0] C_PULSE_MAX_RST = 15'd2500;
    localparam logic [7:0]  C_INTERVAL_RST  = 8'd20;

    typedef enum logic [2:0] {
        CMD_BEGIN     = 3'd0,
        CMD_SET_ANGLE = 3'd1,
        CMD_SET_SPEED = 3'd2,
        CMD_MOVE_TO   = 3'd3,
        CMD_STOP      = 3'd4,
        CMD_TICK      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_PULSE_MIN     = 2'd0,
        CFG_PULSE_MAX     = 2'd1,
        CFG_RAMP_INTERVAL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] target_angle;
        logic [7:0] speed_percent;
        logic [7:0] ramp_step;
    } t_in;

    typedef struct packed {
        logic        duty_valid;
        logic [15:0] duty;
        logic [7:0]  angle_now;
        logic [7:0]  angle_goal;
        logic        moving;
        logic        ready_res;
    } t_out;

    typedef struct packed {
        logic calc;
        t_out res;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- design/srp_front.sv -----
// ----------------------------------------------------------------------------
// Servo ramp PWM controller front end
// Accepts commands, updates servo position state and queues one job per item.
// ----------------------------------------------------------------------------
module srp_front
    import srp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in        i_in_data,
    output logic       o_in_stall,
    input  t_q_stat    i_q_stat,
    input  logic [7:0] i_interval,
    output logic       o_push,
    output t_job       o_job
);

    localparam logic [7:0] C_ANGLE_MAX    = 8'd180;
    localparam logic [7:0] C_ANGLE_CENTRE = 8'd90;

    function automatic logic [7:0] f_cap(input logic [7:0] a);
        f_cap = (a > C_ANGLE_MAX) ? C_ANGLE_MAX : a;
    endfunction

    // (spd*180/100) mod 256 = floor(spd*9/5) mod 256, /5 by reciprocal 6554>>15
    function automatic logic [7:0] f_speed_angle(input logic [7:0] spd);
        logic [11:0] v;
        logic [23:0] p;
        v = {4'd0, spd} * 12'd9;
        p = {12'd0, v} * 24'd6554;
        f_speed_angle = p[22:15];
    endfunction

    logic       r_started, n_started;
    logic [7:0] r_angle, n_angle;
    logic [7:0] r_goal, n_goal;
    logic [7:0] r_step, n_step;
    logic       r_ramping, n_ramping;
    logic [7:0] r_ms, n_ms;

    logic       w_accept;
    logic       w_wrote;
    logic       w_calc;
    logic [7:0] w_ms_inc;
    logic       w_up;
    logic [7:0] w_diff;
    logic [7:0] w_stepped;
    logic [7:0] w_new_angle;

    assign w_accept   = i_in_valid && !i_q_stat.full;
    assign o_in_stall = i_q_stat.full;
    assign o_push     = w_accept;

    assign w_ms_inc  = (r_ms != 8'hFF) ? r_ms + 8'd1 : r_ms;
    assign w_up      = r_goal > r_angle;
    assign w_diff    = w_up ? r_goal - r_angle : r_angle - r_goal;
    assign w_stepped = (w_diff > r_step) ? (w_up ? r_angle + r_step : r_angle - r_step)
                                         : r_goal;
    assign w_new_angle = (i_in_data.cmd == CMD_SET_ANGLE) ? f_cap(i_in_data.target_angle)
                                                          : f_cap(f_speed_angle(
                                                                i_in_data.speed_percent));

    always_comb begin
        n_started = r_started;
        n_angle   = r_angle;
        n_goal    = r_goal;
        n_step    = r_step;
        n_ramping = r_ramping;
        n_ms      = r_ms;
        w_wrote   = 1'b0;
        w_calc    = 1'b0;
        unique case (i_in_data.cmd)
            CMD_TICK: begin
                n_ms = w_ms_inc;
                if (r_started && r_ramping && (w_ms_inc >= i_interval)) begin
                    n_ms = 8'd0;
                    if (r_angle == r_goal) begin
                        n_ramping = 1'b0;
                    end else begin
                        n_angle = w_stepped;
                        w_wrote = 1'b1;
                        w_calc  = 1'b1;
                        if (w_stepped == r_goal) begin
                            n_ramping = 1'b0;
                        end
                    end
                end
            end
            CMD_BEGIN: begin
                if (!r_started) begin
                    n_angle   = C_ANGLE_CENTRE;
                    n_goal    = C_ANGLE_CENTRE;
                    n_ramping = 1'b0;
                    n_started = 1'b1;
                    n_ms      = 8'd0;
                    w_wrote   = 1'b1;
                    w_calc    = 1'b1;
                end
            end
            CMD_SET_ANGLE, CMD_SET_SPEED: begin
                if (r_started) begin
                    n_angle   = w_new_angle;
                    n_goal    = w_new_angle;
                    n_ramping = 1'b0;
                    w_wrote   = 1'b1;
                    w_calc    = 1'b1;
                end
            end
            CMD_MOVE_TO: begin
                if (r_started) begin
                    n_goal    = f_cap(i_in_data.target_angle);
                    n_step    = i_in_data.ramp_step;
                    n_ramping = 1'b1;
                end
            end
            CMD_STOP: begin
                if (r_started) begin
                    n_ramping = 1'b0;
                    w_wrote   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_job.calc           = w_calc;
        o_job.res.duty_valid = w_wrote;
        o_job.res.duty       = 16'd0;
        o_job.res.angle_now  = n_angle;
        o_job.res.angle_goal = n_goal;
        o_job.res.moving     = n_ramping;
        o_job.res.ready_res  = n_started;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_angle   <= C_ANGLE_CENTRE;
            r_goal    <= C_ANGLE_CENTRE;
            r_step    <= 8'd1;
            r_ramping <= 1'b0;
            r_ms      <= 8'd0;
        end else if (w_accept) begin
            r_started <= n_started;
            r_angle   <= n_angle;
            r_goal    <= n_goal;
            r_step    <= n_step;
            r_ramping <= n_ramping;
            r_ms      <= n_ms;
        end
    end

endmodule

// ----- design/srp_queue.sv -----
// ----------------------------------------------------------------------------
// Servo ramp PWM controller job queue
// Small FIFO between the command front end and the duty back end.
// ----------------------------------------------------------------------------
`include "servo_ramp_pwm_controller_core_assert.svh"

module srp_queue
    import srp_pkg::*;
#(
    parameter int DEPTH = C_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        f_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `SRP_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_stat.full, "push into full queue")
    `SRP_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_stat.empty, "pop from empty queue")
    `SRP_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count out of range")

endmodule

// ----- design/srp_duty.sv -----
// ----------------------------------------------------------------------------
// Servo ramp PWM controller duty back end
// Sequential pulse and duty arithmetic with a registered result stage.
// ----------------------------------------------------------------------------
`include "servo_ramp_pwm_controller_core_assert.svh"

module srp_duty
    import srp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_job        i_job,
    output logic        o_pop,
    input  logic [14:0] i_pulse_min,
    input  logic [14:0] i_pulse_max,
    output logic        o_out_valid,
    output t_out        o_out_data,
    input  logic        i_out_stall
);

    // exact reciprocals: x/180 = (x*C_RECIP_180)>>31 for x < 2^23,
    // y/125 = (y*C_RECIP_125)>>31 for y < 2^24
    localparam logic [23:0] C_RECIP_180 = 24'd11930465;
    localparam logic [24:0] C_RECIP_125 = 25'd17179870;
    // 65535/20000 = 13107/4000 = 13107/32/125
    localparam logic [13:0] C_FRAME_MUL = 14'd13107;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_DIV180,
        ST_PULSE,
        ST_FRAME,
        ST_DIV125,
        ST_SAT,
        ST_HOLD
    } t_state;

    t_state      r_state;
    t_out        r_res;
    logic [14:0] r_span;
    logic [22:0] r_x;
    logic [48:0] r_prod;
    logic [14:0] r_pulse;
    logic [28:0] r_y;

    logic [14:0] w_span;
    logic [17:0] w_q;

    assign w_span      = (i_pulse_max > i_pulse_min) ? i_pulse_max - i_pulse_min : 15'd0;
    assign w_q         = r_prod[48:31];
    assign o_pop       = (r_state == ST_IDLE) && !i_q_stat.empty;
    assign o_out_valid = (r_state == ST_HOLD);
    assign o_out_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_res   <= i_job.res;
                        r_span  <= w_span;
                        r_state <= i_job.calc ? ST_SPAN : ST_HOLD;
                    end
                end
                ST_SPAN: begin
                    r_x     <= {15'd0, r_res.angle_now} * {8'd0, r_span};
                    r_state <= ST_DIV180;
                end
                ST_DIV180: begin
                    r_prod  <= {26'd0, r_x} * {25'd0, C_RECIP_180};
                    r_state <= ST_PULSE;
                end
                ST_PULSE: begin
                    r_pulse <= i_pulse_min + r_prod[45:31];
                    r_state <= ST_FRAME;
                end
                ST_FRAME: begin
                    r_y     <= {14'd0, r_pulse} * {15'd0, C_FRAME_MUL};
                    r_state <= ST_DIV125;
                end
                ST_DIV125: begin
                    r_prod  <= {25'd0, r_y[28:5]} * {24'd0, C_RECIP_125};
                    r_state <= ST_SAT;
                end
                ST_SAT: begin
                    r_res.duty <= (w_q > 18'd65535) ? 16'hFFFF : w_q[15:0];
                    r_state    <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (!i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `SRP_ASSERT(a_duty_flagged, i_clk, i_rst_n, (o_out_valid && o_out_data.duty != 16'd0) |-> o_out_data.duty_valid, "nonzero duty without duty_valid")
    `SRP_ASSERT(a_write_started, i_clk, i_rst_n, (o_out_valid && o_out_data.duty_valid) |-> o_out_data.ready_res, "duty written before begin")
    `SRP_ASSERT(a_move_started, i_clk, i_rst_n, (o_out_valid && o_out_data.moving) |-> o_out_data.ready_res, "ramp active before begin")
    `SRP_ASSERT_NEXT(a_pop_busy, i_clk, i_rst_n, o_pop, r_state != ST_IDLE, "back end idle after pop")

endmodule

// ----- design/servo_ramp_pwm_controller_core.sv -----
// ----------------------------------------------------------------------------
// Servo ramp PWM controller core
// Command-driven servo position controller with angle ramping and PWM duty.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one command per
//   transaction: begin, set_angle, set_speed, move_to, stop or a 1 ms tick.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly
//   one result transaction per command, in order.
//   Config channel (i_cfg_valid / o_cfg_ready) writes pulse_min_us,
//   pulse_max_us and ramp_interval_ms; it is always ready. Write it only
//   while no command is in flight.
//   Items that compute no duty go from the queue straight to the result;
//   items that compute one first pass the span, divide-by-180, pulse,
//   frame, divide-by-125 and saturate states. The duty back end works on
//   one item at a time and pops the next only after the result is taken.
//   The front end keeps taking commands into a 2-entry job queue while the
//   back end computes or the receiver stalls; o_in_stall rises when the
//   queue is full. A stalled result holds on o_out_data.
//   Reset clears position state to 90 degrees, not started, and restores
//   the register defaults.
// ----------------------------------------------------------------------------
module servo_ramp_pwm_controller_core
    import srp_pkg::*;
#(
    parameter int QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    logic [14:0] r_pulse_min;
    logic [14:0] r_pulse_max;
    logic [7:0]  r_interval;

    logic    w_push;
    logic    w_pop;
    t_job    w_job_in;
    t_job    w_job_out;
    t_q_stat w_q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min <= C_PULSE_MIN_RST;
            r_pulse_max <= C_PULSE_MAX_RST;
            r_interval  <= C_INTERVAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PULSE_MIN:     r_pulse_min <= i_cfg_data;
                CFG_PULSE_MAX:     r_pulse_max <= i_cfg_data;
                CFG_RAMP_INTERVAL: r_interval  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    srp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_stat   (w_q_stat),
        .i_interval (r_interval),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    srp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    srp_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_job       (w_job_out),
        .o_pop       (w_pop),
        .i_pulse_min (r_pulse_min),
        .i_pulse_max (r_pulse_max),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
